FILE: rtl/rgb2hsv_pkg.sv
`default_nettype none

package rgb2hsv_pkg;

   // Field widths
   localparam int CHAN_W = 8;
   localparam int HUE_W  = 9;
   localparam int PCT_W  = 15;
   localparam int DIV_W  = 8;     // every divisor fits one channel
   localparam int T_W    = 17;    // hue dividend, at most 420 * 255

   // Divider lanes
   localparam int NUM_LANES = 3;
   localparam int LANE_HUE  = 0;
   localparam int LANE_SAT  = 1;
   localparam int LANE_VAL  = 2;

   // Hue constants
   localparam int               HUE_STEP      = 60;
   localparam logic [HUE_W-1:0] HUE_OFF_RED   = 9'd360;
   localparam logic [HUE_W-1:0] HUE_OFF_GREEN = 9'd120;
   localparam logic [HUE_W-1:0] HUE_OFF_BLUE  = 9'd240;
   localparam logic [HUE_W-1:0] HUE_WRAP      = 9'd360;

   // Percent scaling
   localparam int                PCT_FULL = 100;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic valid;
      logic grey;    // max equals min
      logic black;   // max is zero
   } ctl_type;

endpackage

`default_nettype wire

FILE: rtl/rgb_to_hsv_converter_unit.sv
`default_nettype none

// RGB to HSV converter.
//
// Input: raise start with req_red / req_green / req_blue; an item is taken at
// any rising edge where start is high and busy is low. busy is always low, so
// one pixel may be offered on every clock.
// Output: rsp_valid strobes for one cycle with rsp_hue_degrees (0..359),
// rsp_saturation_pct and rsp_value_pct (percent, FRAC_BITS fraction bits).
// The receiver cannot stall; results come out in input order, one per item.
// Pipeline: two front stages (channel sort, then dividends), a row of NUM_STEPS
// divider cells, where NUM_STEPS = max(9, FRAC_BITS + 7) (15 at FRAC_BITS = 8),
// that each retire one quotient bit for hue, saturation and value at once, and
// the output register with the hue wrap.
// Throughput: one item per clock.
// Reset (synchronous): drops every item in flight; no result follows.
module rgb_to_hsv_converter_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [rgb2hsv_pkg::CHAN_W-1:0]  req_red,
   input  logic [rgb2hsv_pkg::CHAN_W-1:0]  req_green,
   input  logic [rgb2hsv_pkg::CHAN_W-1:0]  req_blue,
   output logic                            rsp_valid,
   output logic [rgb2hsv_pkg::HUE_W-1:0]   rsp_hue_degrees,
   output logic [rgb2hsv_pkg::PCT_W-1:0]   rsp_saturation_pct,
   output logic [rgb2hsv_pkg::PCT_W-1:0]   rsp_value_pct
);
   import rgb2hsv_pkg::*;

   // quotient bits per lane: hue needs 9, the percents FRAC_BITS + 7
   localparam int NUM_STEPS = (FRAC_BITS + 7 > HUE_W) ? FRAC_BITS + 7 : HUE_W;
   localparam int EXT_W     = (NUM_STEPS > PCT_W) ? NUM_STEPS : PCT_W;
   localparam int LATENCY   = NUM_STEPS + 3;

   logic take;

   // pipeline links; index 0 is the prep output, NUM_STEPS the last cell
   ctl_type                             ctl_c [NUM_STEPS+1];
   logic [NUM_LANES-1:0][DIV_W-1:0]     div_c [NUM_STEPS+1];
   logic [NUM_LANES-1:0][DIV_W-1:0]     rem_c [NUM_STEPS+1];
   logic [NUM_LANES-1:0][NUM_STEPS-1:0] acc_c [NUM_STEPS+1];

   assign busy = 1'b0;
   assign take = start && !busy;

   rgb2hsv_prep #(
      .FRAC_BITS (FRAC_BITS),
      .NUM_STEPS (NUM_STEPS)
   ) u_prep (
      .clock   (clock),
      .reset   (reset),
      .take_i  (take),
      .red_i   (req_red),
      .green_i (req_green),
      .blue_i  (req_blue),
      .ctl_o   (ctl_c[0]),
      .div_o   (div_c[0]),
      .rem_o   (rem_c[0]),
      .acc_o   (acc_c[0])
   );

   // one cell per quotient bit, MSB first
   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
      rgb2hsv_div_cell #(
         .NUM_STEPS (NUM_STEPS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl_i (ctl_c[i]),
         .div_i (div_c[i]),
         .rem_i (rem_c[i]),
         .acc_i (acc_c[i]),
         .ctl_o (ctl_c[i+1]),
         .div_o (div_c[i+1]),
         .rem_o (rem_c[i+1]),
         .acc_o (acc_c[i+1])
      );
   end

   // output stage: hue quotient is at most 420, so one subtract wraps it
   ctl_type            ctl_end;
   logic [HUE_W-1:0]   hue_q;
   logic [EXT_W-1:0]   sat_ext, val_ext;
   logic               rsp_valid_in, rsp_valid_ff;
   logic [HUE_W-1:0]   hue_in, hue_ff;
   logic [PCT_W-1:0]   sat_in, sat_ff, val_in, val_ff;

   always_comb begin
      ctl_end = ctl_c[NUM_STEPS];
      hue_q   = acc_c[NUM_STEPS][LANE_HUE][HUE_W-1:0];
      sat_ext = EXT_W'(acc_c[NUM_STEPS][LANE_SAT]);
      val_ext = EXT_W'(acc_c[NUM_STEPS][LANE_VAL]);

      rsp_valid_in = ctl_end.valid;

      if (ctl_end.grey) begin
         hue_in = '0;                 // grey pixel: hue undefined, report zero
      end else if (hue_q >= HUE_WRAP) begin
         hue_in = hue_q - HUE_WRAP;
      end else begin
         hue_in = hue_q;
      end

      // black pixel divided by zero: saturation forced to zero
      sat_in = ctl_end.black ? '0 : sat_ext[PCT_W-1:0];
      val_in = val_ext[PCT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      hue_ff <= hue_in;
      sat_ff <= sat_in;
      val_ff <= val_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hue_degrees    = hue_ff;
   assign rsp_saturation_pct = sat_ff;
   assign rsp_value_pct      = val_ff;

`ifndef SYNTHESIS
   // every result traces back to an item that was taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_degrees < HUE_WRAP)
      else $error("hue out of range");

   // a black pixel must come out all zero, value included
   assert property (@(posedge clock) disable iff (reset)
      ctl_end.valid && ctl_end.black |=>
         rsp_hue_degrees == '0 && rsp_saturation_pct == '0 && rsp_value_pct == '0)
      else $error("black pixel gave nonzero result");

   // division invariant: final value lane remainder below its divisor
   assert property (@(posedge clock) disable iff (reset)
      ctl_end.valid |->
         rem_c[NUM_STEPS][LANE_VAL] < div_c[NUM_STEPS][LANE_VAL])
      else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/rgb2hsv_prep.sv
`default_nettype none

module rgb2hsv_prep #(
   parameter int FRAC_BITS = 8,
   parameter int NUM_STEPS = 15
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    take_i,
   input  logic [rgb2hsv_pkg::CHAN_W-1:0]                          red_i,
   input  logic [rgb2hsv_pkg::CHAN_W-1:0]                          green_i,
   input  logic [rgb2hsv_pkg::CHAN_W-1:0]                          blue_i,
   output rgb2hsv_pkg::ctl_type                                    ctl_o,
   output logic [rgb2hsv_pkg::NUM_LANES-1:0][rgb2hsv_pkg::DIV_W-1:0] div_o,
   output logic [rgb2hsv_pkg::NUM_LANES-1:0][rgb2hsv_pkg::DIV_W-1:0] rem_o,
   output logic [rgb2hsv_pkg::NUM_LANES-1:0][NUM_STEPS-1:0]         acc_o
);
   import rgb2hsv_pkg::*;

   localparam int              DVW   = DIV_W + NUM_STEPS;
   localparam logic [DVW-1:0]  SCALE = DVW'(PCT_FULL) << FRAC_BITS;

   // stage 1: sort channels
   sector_type         sector_in, sector_ff;
   logic [CHAN_W-1:0]  mx_in, mx_ff;
   logic [CHAN_W-1:0]  mn_in;
   logic [CHAN_W-1:0]  d_ff;
   logic signed [CHAN_W:0] num_in, num_ff;
   logic               valid1_ff;

   always_comb begin
      if (red_i >= green_i && red_i >= blue_i) begin
         sector_in = SECT_RED;
         mx_in     = red_i;
      end else if (green_i >= blue_i) begin
         sector_in = SECT_GREEN;
         mx_in     = green_i;
      end else begin
         sector_in = SECT_BLUE;
         mx_in     = blue_i;
      end

      if (red_i <= green_i && red_i <= blue_i) begin
         mn_in = red_i;
      end else if (green_i <= blue_i) begin
         mn_in = green_i;
      end else begin
         mn_in = blue_i;
      end

      case (sector_in)
         SECT_RED:   num_in = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
         SECT_GREEN: num_in = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
         SECT_BLUE:  num_in = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
         default:    num_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= take_i;
      end
      sector_ff <= sector_in;
      mx_ff     <= mx_in;
      d_ff      <= mx_in - mn_in;
      num_ff    <= num_in;
   end

   // stage 2: dividends and divisors
   logic [HUE_W-1:0]        off;
   logic [T_W-1:0]          off_d;
   logic signed [15:0]      step_term;
   logic signed [T_W+1:0]   t_sum;
   logic [DVW-1:0]          hue_dvd, sat_dvd, val_dvd;
   ctl_type                 ctl_in, ctl_ff;
   logic [NUM_LANES-1:0][DIV_W-1:0]     div_in, div_ff, rem_in, rem_ff;
   logic [NUM_LANES-1:0][NUM_STEPS-1:0] acc_in, acc_ff;

   always_comb begin
      case (sector_ff)
         SECT_RED:   off = HUE_OFF_RED;
         SECT_GREEN: off = HUE_OFF_GREEN;
         SECT_BLUE:  off = HUE_OFF_BLUE;
         default:    off = '0;
      endcase
      off_d     = T_W'(off) * T_W'(d_ff);
      step_term = 16'(num_ff) * 16'(HUE_STEP);
      // never negative: num lies in [-d, d] and off is at least 2 * 60
      t_sum     = $signed({2'b00, off_d}) + (T_W+2)'(step_term);
      hue_dvd   = DVW'(t_sum[T_W-1:0]);
      sat_dvd   = DVW'(d_ff) * SCALE;
      val_dvd   = DVW'(mx_ff) * SCALE;

      div_in[LANE_HUE] = d_ff;
      div_in[LANE_SAT] = mx_ff;
      div_in[LANE_VAL] = CHAN_MAX;
      rem_in[LANE_HUE] = hue_dvd[DVW-1:NUM_STEPS];
      rem_in[LANE_SAT] = sat_dvd[DVW-1:NUM_STEPS];
      rem_in[LANE_VAL] = val_dvd[DVW-1:NUM_STEPS];
      acc_in[LANE_HUE] = hue_dvd[NUM_STEPS-1:0];
      acc_in[LANE_SAT] = sat_dvd[NUM_STEPS-1:0];
      acc_in[LANE_VAL] = val_dvd[NUM_STEPS-1:0];

      ctl_in.valid = valid1_ff;
      ctl_in.grey  = (d_ff == '0);
      ctl_in.black = (mx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign ctl_o = ctl_ff;
   assign div_o = div_ff;
   assign rem_o = rem_ff;
   assign acc_o = acc_ff;

`ifndef SYNTHESIS
   // a black pixel has all channels equal
   assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid && ctl_ff.black |-> ctl_ff.grey)
      else $error("black pixel not flagged grey");
`endif

endmodule

`default_nettype wire

FILE: rtl/rgb2hsv_div_cell.sv
`default_nettype none

// One restoring-division step for all three lanes.
module rgb2hsv_div_cell #(
   parameter int NUM_STEPS = 15
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  rgb2hsv_pkg::ctl_type                                    ctl_i,
   input  logic [rgb2hsv_pkg::NUM_LANES-1:0][rgb2hsv_pkg::DIV_W-1:0] div_i,
   input  logic [rgb2hsv_pkg::NUM_LANES-1:0][rgb2hsv_pkg::DIV_W-1:0] rem_i,
   input  logic [rgb2hsv_pkg::NUM_LANES-1:0][NUM_STEPS-1:0]         acc_i,
   output rgb2hsv_pkg::ctl_type                                    ctl_o,
   output logic [rgb2hsv_pkg::NUM_LANES-1:0][rgb2hsv_pkg::DIV_W-1:0] div_o,
   output logic [rgb2hsv_pkg::NUM_LANES-1:0][rgb2hsv_pkg::DIV_W-1:0] rem_o,
   output logic [rgb2hsv_pkg::NUM_LANES-1:0][NUM_STEPS-1:0]         acc_o
);
   import rgb2hsv_pkg::*;

   logic [NUM_LANES-1:0][DIV_W:0]       cand, diff;
   logic [NUM_LANES-1:0]                fits;
   logic [NUM_LANES-1:0][DIV_W-1:0]     rem_in, rem_ff, div_ff;
   logic [NUM_LANES-1:0][NUM_STEPS-1:0] acc_in, acc_ff;
   ctl_type                             ctl_ff;

   // acc holds the dividend bits still to come on top, quotient bits below
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         cand[l]   = {rem_i[l], acc_i[l][NUM_STEPS-1]};
         diff[l]   = cand[l] - {1'b0, div_i[l]};
         fits[l]   = (cand[l] >= {1'b0, div_i[l]});
         rem_in[l] = fits[l] ? diff[l][DIV_W-1:0] : cand[l][DIV_W-1:0];
         acc_in[l] = {acc_i[l][NUM_STEPS-2:0], fits[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      div_ff <= div_i;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign ctl_o = ctl_ff;
   assign div_o = div_ff;
   assign rem_o = rem_ff;
   assign acc_o = acc_ff;

endmodule

`default_nettype wire

FILE: bench/tb_rgb_to_hsv_converter_unit.sv
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;
   import rgb2hsv_pkg::*;

   // Block configuration and timing
   localparam int FRAC_BITS = 8;
   localparam int NUM_STEPS = (FRAC_BITS + 7 > 9) ? FRAC_BITS + 7 : 9;
   localparam int LATENCY   = NUM_STEPS + 3;    // accept edge to result edge
   localparam int WATCHDOG_LIMIT = 2000;        // cycles with no item moving
   localparam int IDLE_PCT  = 26;

   // One converted pixel as the block should report it
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] sat;
      logic [PCT_W-1:0] val;
   } hsv_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CHAN_W-1:0] req_red   = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue  = '0;
   logic              rsp_valid;
   logic [HUE_W-1:0]  rsp_hue_degrees;
   logic [PCT_W-1:0]  rsp_saturation_pct;
   logic [PCT_W-1:0]  rsp_value_pct;

   hsv_type expected_hsv_q[$];     // predicted results, oldest first
   int      idle_pct        = IDLE_PCT;
   int      pixels_sent     = 0;
   int      results_checked = 0;
   int      error_count     = 0;
   int      quiet_cycles    = 0;

   rgb_to_hsv_converter_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .rsp_valid          (rsp_valid),
      .rsp_hue_degrees    (rsp_hue_degrees),
      .rsp_saturation_pct (rsp_saturation_pct),
      .rsp_value_pct      (rsp_value_pct)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor: integer HSV, everything truncated.
   function automatic hsv_type predict_hsv(input logic [CHAN_W-1:0] r,
                                           input logic [CHAN_W-1:0] g,
                                           input logic [CHAN_W-1:0] b);
      hsv_type     res;
      sector_type  sect;
      int unsigned ri;
      int unsigned gi;
      int unsigned bi;
      int unsigned mx;
      int unsigned mn;
      int unsigned d;
      int unsigned scale;
      int          num;
      int          off;
      int          hue_i;
      ri    = 32'(r);
      gi    = 32'(g);
      bi    = 32'(b);
      mx    = ri;
      mn    = ri;
      sect  = SECT_RED;
      scale = PCT_FULL << FRAC_BITS;
      // strict compares: red wins a tie, then green
      if (gi > mx) begin
         mx   = gi;
         sect = SECT_GREEN;
      end
      if (bi > mx) begin
         mx   = bi;
         sect = SECT_BLUE;
      end
      if (gi < mn) mn = gi;
      if (bi < mn) mn = bi;
      d     = mx - mn;
      hue_i = 0;
      if (d != 0) begin
         case (sect)
            SECT_RED: begin
               num = int'(g) - int'(b);
               off = int'(HUE_OFF_RED);
            end
            SECT_GREEN: begin
               num = int'(b) - int'(r);
               off = int'(HUE_OFF_GREEN);
            end
            default: begin
               num = int'(r) - int'(g);
               off = int'(HUE_OFF_BLUE);
            end
         endcase
         // dividend stays positive since |num| <= d and off >= 120
         hue_i = (HUE_STEP * num + off * int'(d)) / int'(d);
         if (hue_i >= int'(HUE_WRAP)) hue_i -= int'(HUE_WRAP);
      end
      res.hue = hue_i[HUE_W-1:0];
      res.sat = (mx != 0) ? PCT_W'((d * scale) / mx) : '0;
      res.val = PCT_W'((mx * scale) / int'(CHAN_MAX));
      return res;
   endfunction

   // Offer one pixel. Entered and left right after a falling edge; start
   // stays high if the next call sends at once, so it never toggles in a step.
   task automatic send_pixel(input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_hsv_q.push_back(predict_hsv(r, g, b));
      pixels_sent++;
      @(negedge clock);
   endtask

   // Black, white, primaries, secondaries, one-step corners.
   task automatic test_extremes();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd254, 8'd255, 8'd254);
   endtask

   // Two channels share the maximum: red beats green or blue, green beats blue.
   task automatic test_max_ties();
      send_pixel(8'd200, 8'd200, 8'd50);
      send_pixel(8'd50,  8'd200, 8'd200);
      send_pixel(8'd200, 8'd50,  8'd200);
   endtask

   // Greys of several levels give hue 0 and saturation 0.
   task automatic test_grey_and_black();
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd77,  8'd77,  8'd77);
   endtask

   // Red sector wraps through 360; green/blue sector edges.
   task automatic test_hue_wrap();
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd1,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd1,   8'd255);
   endtask

   // Long stretch with start held high on every clock.
   task automatic test_back_to_back(input int count);
      idle_pct = 0;
      repeat (count) send_pixel(CHAN_W'($urandom_range(255)),
                                CHAN_W'($urandom_range(255)),
                                CHAN_W'($urandom_range(255)));
      idle_pct = IDLE_PCT;
   endtask

   // Random pixels, biased toward greys, ties, near-greys, dark colors and channel extremes.
   task automatic test_random_pixels(input int count);
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      int                m;
      int                lo;
      repeat (count) begin
         r = CHAN_W'($urandom_range(255));
         g = CHAN_W'($urandom_range(255));
         b = CHAN_W'($urandom_range(255));
         case ($urandom_range(9))
            5: begin                        // grey
               g = r;
               b = r;
            end
            6: begin                        // tie for the maximum
               m  = $urandom_range(255);
               lo = $urandom_range(m);
               case ($urandom_range(2))
                  0: begin r = CHAN_W'(m);  g = CHAN_W'(m);  b = CHAN_W'(lo); end
                  1: begin r = CHAN_W'(lo); g = CHAN_W'(m);  b = CHAN_W'(m);  end
                  default: begin r = CHAN_W'(m); g = CHAN_W'(lo); b = CHAN_W'(m); end
               endcase
            end
            7: begin                        // tiny max - min
               m = $urandom_range(252);
               r = CHAN_W'(m + $urandom_range(3));
               g = CHAN_W'(m + $urandom_range(3));
               b = CHAN_W'(m + $urandom_range(3));
            end
            8: begin                        // very dark
               r = CHAN_W'($urandom_range(7));
               g = CHAN_W'($urandom_range(7));
               b = CHAN_W'($urandom_range(7));
            end
            9: begin                        // red may go to 255, blue to 0
               r = $urandom_range(1) ? 8'd255 : r;
               b = $urandom_range(1) ? 8'd0 : b;
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
   endtask

   // Result checker: every strobe must match the oldest prediction.
   always @(posedge clock) begin : check_results
      hsv_type want;
      if (!reset && rsp_valid) begin
         if (expected_hsv_q.size() == 0) begin
            $error("unexpected result: hue_degrees %0d saturation_pct %0d value_pct %0d",
                   rsp_hue_degrees, rsp_saturation_pct, rsp_value_pct);
            error_count++;
         end else begin
            want = expected_hsv_q.pop_front();
            if (rsp_hue_degrees !== want.hue) begin
               $error("hue_degrees: expected %0d, actual %0d", want.hue, rsp_hue_degrees);
               error_count++;
            end
            if (rsp_saturation_pct !== want.sat) begin
               $error("saturation_pct: expected %0d, actual %0d",
                      want.sat, rsp_saturation_pct);
               error_count++;
            end
            if (rsp_value_pct !== want.val) begin
               $error("value_pct: expected %0d, actual %0d", want.val, rsp_value_pct);
               error_count++;
            end
            results_checked++;
         end
      end
   end

   // Watchdog: too long with no item accepted and no result means a hang.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, expected_hsv_q.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extremes();
      test_max_ties();
      test_grey_and_black();
      test_hue_wrap();
      test_back_to_back(150);
      test_random_pixels(680);

      start <= 1'b0;
      // drain, then watch a little longer for stray results
      while (expected_hsv_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      $display("Converted %0d pixels: extremes, max ties, greys, hue wrap, back-to-back, random",
               pixels_sent);
      $display("Checked %0d results, %0d mismatches", results_checked, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
